// ----- sv/dmcg_pkg.sv -----
// Shared constants, types and the glyph ROM of the dot matrix character generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dmcg_pkg;

    localparam int TEXT_COLUMNS  = 8;
    localparam int TEXT_LINES    = 2;
    localparam int CHAR_GAP      = 1;
    localparam int LINE_GAP_ROWS = 1;

    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int GLYPH_COUNT = 47;
    localparam int PUNCT_BASE  = 36;

    localparam int STORE_DEPTH = TEXT_LINES * TEXT_COLUMNS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int COL_W = 8;
    localparam int ROW_W = 5;
    localparam int GX_W  = 3;
    localparam int GY_W  = 3;

    // Pitches of one character cell and one text line, and the fixed-point
    // reciprocals used to split a coordinate without a divider.
    localparam int COL_PITCH = GLYPH_W + CHAR_GAP;
    localparam int ROW_PITCH = GLYPH_H + LINE_GAP_ROWS;
    localparam int RECIP_SH  = 16;
    localparam int COL_RECIP = (1 << RECIP_SH) / COL_PITCH;
    localparam int ROW_RECIP = (1 << RECIP_SH) / ROW_PITCH;
    localparam int SLOT_W    = $clog2((1 << COL_W) / COL_PITCH + 2);
    localparam int LINE_W    = $clog2((1 << ROW_W) / ROW_PITCH + 2);

    localparam logic [7:0] SPACE_CODE = 8'h20;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } dmcg_func_t;

    // Result of splitting a pixel coordinate into store address and glyph cell.
    typedef struct packed
    {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [GX_W-1:0]   gx;
        logic [GY_W-1:0]   gy;
    } dmcg_pix_t;

    // Column-major glyphs, bit 0 is the top row: A-Z, 0-9, then punctuation.
    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_W] = '{
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h26, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
        '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}, '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
        '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00}, '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
        '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62}
    };

    // Column bits of the glyph for a code; zero where the code has no glyph.
    function automatic logic [7:0] glyph_column(input logic [7:0] code,
                                                input logic [GX_W-1:0] gx);
        logic [5:0] idx;
        logic       known;
        idx   = 6'd0;
        known = 1'b1;
        if (code >= 8'h41 && code <= 8'h5A)
        begin
            idx = 6'(code - 8'h41);
        end
        else if (code >= 8'h30 && code <= 8'h39)
        begin
            idx = 6'(code - 8'h30 + 8'd26);
        end
        else
        begin
            case (code)
                8'h20:   idx = 6'(PUNCT_BASE + 0);
                8'h2E:   idx = 6'(PUNCT_BASE + 1);
                8'h2D:   idx = 6'(PUNCT_BASE + 2);
                8'h2B:   idx = 6'(PUNCT_BASE + 3);
                8'h2F:   idx = 6'(PUNCT_BASE + 4);
                8'h5F:   idx = 6'(PUNCT_BASE + 5);
                8'h3F:   idx = 6'(PUNCT_BASE + 6);
                8'h3A:   idx = 6'(PUNCT_BASE + 7);
                8'h28:   idx = 6'(PUNCT_BASE + 8);
                8'h29:   idx = 6'(PUNCT_BASE + 9);
                8'h25:   idx = 6'(PUNCT_BASE + 10);
                default: known = 1'b0;
            endcase
        end
        if (!known || 32'(gx) >= GLYPH_W)
        begin
            return 8'h00;
        end
        return FONT_ROM[idx][gx];
    endfunction

endpackage

`default_nettype wire

// ----- sv/dot_matrix_character_generator_top.sv -----
// Top level of the dot matrix character generator: input register, text store,
// coordinate split, font lookup and result register. Depends on dmcg_pkg,
// dmcg_coord_split and dmcg_text_store.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock cycle on the input channel, whether a slot write or
// a pixel query, unless a query is stalled in the input register. A query's
// answer is loaded from the input register into the result register; the path
// between is one pass of coordinate split, text store read and font ROM lookup.
// A write updates the store as it leaves the input register and gives no
// result, and any later query sees it. Words keep flowing while a result waits
// to be taken, until a query is held in the input register.
module dot_matrix_character_generator_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       func,
    input  wire logic       line_sel,
    input  wire logic [4:0] slot_pos,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] pixel_col,
    input  wire logic [4:0] pixel_row,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            dot_on
);

    logic       valid_reg;
    logic       func_reg;
    logic       line_reg;
    logic [4:0] pos_reg;
    logic [7:0] code_reg;
    logic [7:0] col_reg;
    logic [4:0] row_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       dot_reg;
    logic       dot_next;
    logic       advance;
    logic       is_query;
    logic       wr_en;
    logic [dmcg_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0] rd_code;
    logic [7:0] glyph_bits;
    dmcg_pkg::dmcg_pix_t pix;

    assign is_query = (func_reg == dmcg_pkg::FUNC_QUERY);
    // A write always leaves; a query leaves once the result register is free.
    assign advance  = valid_reg && (!is_query || !out_valid_reg || out_ready);
    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= func;
            line_reg <= line_sel;
            pos_reg  <= slot_pos;
            code_reg <= char_code;
            col_reg  <= pixel_col;
            row_reg  <= pixel_row;
        end
    end

    always_comb
    begin
        wr_en   = advance && !is_query
               && (32'(line_reg) < dmcg_pkg::TEXT_LINES)
               && (32'(pos_reg) < dmcg_pkg::TEXT_COLUMNS);
        wr_addr = dmcg_pkg::ADDR_W'(32'(line_reg) * dmcg_pkg::TEXT_COLUMNS + 32'(pos_reg));
    end

    dmcg_text_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_code (code_reg),
        .rd_addr (pix.addr),
        .rd_code (rd_code)
    );

    dmcg_coord_split u_split
    (
        .pixel_col (col_reg),
        .pixel_row (row_reg),
        .pix       (pix)
    );

    always_comb
    begin
        glyph_bits = dmcg_pkg::glyph_column(rd_code, pix.gx);
        dot_next   = pix.hit && glyph_bits[pix.gy];
        if (advance && is_query)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_query)
        begin
            dot_reg <= dot_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dot_on    = dot_reg;

endmodule

`default_nettype wire

// ----- sv/dmcg_coord_split.sv -----
// Splits a dot matrix coordinate into text store address and glyph cell.
// Depends on dmcg_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module dmcg_coord_split
(
    input  wire logic [dmcg_pkg::COL_W-1:0] pixel_col,
    input  wire logic [dmcg_pkg::ROW_W-1:0] pixel_row,
    output dmcg_pkg::dmcg_pix_t             pix
);

    localparam int COL_PROD_W = dmcg_pkg::COL_W + dmcg_pkg::RECIP_SH + 1;
    localparam int ROW_PROD_W = dmcg_pkg::ROW_W + dmcg_pkg::RECIP_SH + 1;

    logic [COL_PROD_W-1:0]          col_prod;
    logic [ROW_PROD_W-1:0]          row_prod;
    logic [dmcg_pkg::SLOT_W-1:0]    slot_est;
    logic [dmcg_pkg::LINE_W-1:0]    line_est;
    logic [dmcg_pkg::COL_W-1:0]     gx_est;
    logic [dmcg_pkg::ROW_W-1:0]     gy_est;
    logic [dmcg_pkg::SLOT_W-1:0]    slot;
    logic [dmcg_pkg::LINE_W-1:0]    line;
    logic [dmcg_pkg::COL_W-1:0]     gx;
    logic [dmcg_pkg::ROW_W-1:0]     gy;

    // The reciprocal rounds down, so the estimate is the quotient or one less.
    always_comb
    begin
        col_prod = COL_PROD_W'(pixel_col) * COL_PROD_W'(dmcg_pkg::COL_RECIP);
        row_prod = ROW_PROD_W'(pixel_row) * ROW_PROD_W'(dmcg_pkg::ROW_RECIP);
        slot_est = dmcg_pkg::SLOT_W'(col_prod >> dmcg_pkg::RECIP_SH);
        line_est = dmcg_pkg::LINE_W'(row_prod >> dmcg_pkg::RECIP_SH);
        gx_est   = pixel_col - dmcg_pkg::COL_W'(32'(slot_est) * dmcg_pkg::COL_PITCH);
        gy_est   = pixel_row - dmcg_pkg::ROW_W'(32'(line_est) * dmcg_pkg::ROW_PITCH);

        if (32'(gx_est) >= dmcg_pkg::COL_PITCH)
        begin
            slot = slot_est + 1'b1;
            gx   = gx_est - dmcg_pkg::COL_W'(dmcg_pkg::COL_PITCH);
        end
        else
        begin
            slot = slot_est;
            gx   = gx_est;
        end

        if (32'(gy_est) >= dmcg_pkg::ROW_PITCH)
        begin
            line = line_est + 1'b1;
            gy   = gy_est - dmcg_pkg::ROW_W'(dmcg_pkg::ROW_PITCH);
        end
        else
        begin
            line = line_est;
            gy   = gy_est;
        end

        pix.hit  = (32'(slot) < dmcg_pkg::TEXT_COLUMNS) && (32'(gx) < dmcg_pkg::GLYPH_W)
                && (32'(line) < dmcg_pkg::TEXT_LINES) && (32'(gy) < dmcg_pkg::GLYPH_H);
        pix.addr = dmcg_pkg::ADDR_W'(32'(line) * dmcg_pkg::TEXT_COLUMNS + 32'(slot));
        pix.gx   = dmcg_pkg::GX_W'(gx);
        pix.gy   = dmcg_pkg::GY_W'(gy);
    end

endmodule

`default_nettype wire

// ----- sv/dmcg_text_store.sv -----
// Text store: one character code per slot, reset to space, one write port
// and one read port. Depends on dmcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmcg_text_store
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [dmcg_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                  wr_code,
    input  wire logic [dmcg_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                       rd_code
);

    logic [7:0] slot_reg [dmcg_pkg::STORE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dmcg_pkg::STORE_DEPTH; i++)
            begin
                slot_reg[i] <= dmcg_pkg::SPACE_CODE;
            end
        end
        else if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_code;
        end
    end

    // An address past the store only arises for a miss, which renders dark anyway.
    always_comb
    begin
        if (32'(rd_addr) < dmcg_pkg::STORE_DEPTH)
        begin
            rd_code = slot_reg[rd_addr];
        end
        else
        begin
            rd_code = dmcg_pkg::SPACE_CODE;
        end
    end

endmodule

`default_nettype wire
